// ===== hw/rtl/pfsd_pkg.sv =====
// Shared types, widths, constants and codes of the plate force spring damper step
package pfsd_pkg;

  // field widths
  localparam int unsigned F_W        = 40;   // forces and velocity
  localparam int unsigned T_W        = 48;   // translation and anchor
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned NET_W      = 42;   // residual and net force sums
  localparam int unsigned SUM_W      = 51;   // wide sums before saturation

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COMPACTION_FORCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_STIFFNESS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_FRACTION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS_DAMP_COEFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_VELOCITY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_CAP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_START_STEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_START_STEP   = 3'd7;

  // register reset values
  localparam logic [38:0] RST_COMPACTION_FORCE    = 39'd25000000;
  localparam logic [31:0] RST_SPRING_STIFFNESS    = 32'd5002500;
  localparam logic [15:0] RST_DAMPING_FRACTION    = 16'd45875;
  localparam logic [39:0] RST_VISCOUS_DAMP_COEFF  = 40'd2500000000;
  localparam logic [31:0] RST_APPROACH_VELOCITY   = 32'd1073742;
  localparam logic [31:0] RST_VELOCITY_CAP        = 32'd966368;
  localparam logic [31:0] RST_COUPLING_START_STEP = 32'd25;
  localparam logic [31:0] RST_SPRING_START_STEP   = 32'd2550;

  // fixed scale factors
  localparam logic [23:0] STEP_TIME_Q16        = 24'd131072;
  localparam logic [23:0] VELOCITY_GAIN_Q8     = 24'd18325;
  localparam logic [15:0] TRIGGER_FRACTION_Q16 = 16'd62259;

  // phase codes
  localparam logic [1:0] PHASE_OFF     = 2'd0;
  localparam logic [1:0] PHASE_COMPACT = 2'd1;
  localparam logic [1:0] PHASE_SPRING  = 2'd2;

  // shared multiplier geometry
  localparam int unsigned MUL_A_W   = 49;   // signed operand
  localparam int unsigned MUL_MAG_W = 49;   // its magnitude
  localparam int unsigned MUL_DIG_W = 16;
  localparam int unsigned MUL_NDIG  = 3;
  localparam int unsigned MUL_B_W   = MUL_DIG_W * MUL_NDIG;
  localparam int unsigned MUL_ACC_W = MUL_MAG_W + MUL_B_W;
  localparam int unsigned MUL_RES_W = MUL_MAG_W + 1;
  localparam int unsigned MUL_OP_W  = 3;

  // multiplier operations: each fixes the scaling shift and the clamp
  localparam logic [MUL_OP_W-1:0] MOP_VISC   = 3'd0;
  localparam logic [MUL_OP_W-1:0] MOP_SPRING = 3'd1;
  localparam logic [MUL_OP_W-1:0] MOP_DAMP   = 3'd2;
  localparam logic [MUL_OP_W-1:0] MOP_TRIG   = 3'd3;
  localparam logic [MUL_OP_W-1:0] MOP_DV     = 3'd4;
  localparam logic [MUL_OP_W-1:0] MOP_DX     = 3'd5;

  // clamp limits
  localparam logic [MUL_MAG_W-1:0] MLIM_F   = 49'h00_7F_FFFF_FFFF;
  localparam logic [MUL_MAG_W-1:0] MLIM_DV  = 49'h00_200_0000_0000;
  localparam logic [MUL_MAG_W-1:0] MLIM_DX  = 49'h1_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] SLIM_F = 51'sh7F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SLIM_T = 51'sh7FFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [F_W-1:0] measured_force_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [T_W-1:0] translation_z;
    logic signed [F_W-1:0] velocity_z;
    logic signed [F_W-1:0] drive_force_z;
    logic signed [F_W-1:0] damping_force_z;
    logic [1:0]            phase;
    logic                  force_mode;
  } out_beat_t;

  typedef struct packed {
    logic                      start;
    logic [MUL_OP_W-1:0]       op;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                        busy;
    logic                        done;
    logic signed [MUL_RES_W-1:0] res;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/pfsd_stream_if.sv =====
// Valid/ready stream channel carrying one beat of a typed payload
interface pfsd_stream_if #(
  parameter type beat_t = logic
) ();
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/plate_force_spring_damper_step.sv =====
// Top level of the plate force spring damper step: sequencer, state and configuration
//
// Each input beat is one exchange step carrying the measured z force on the plate, and
// each gives exactly one result beat. A step at or before the coupling start runs no
// product. A coupled step runs its products one after another through a single shared
// multiplier (three 16-bit digits, then scaling and clamping). The input is ready only
// while the sequencer is idle; a finished result sits in the output register, so the
// next step is taken while the previous result waits, and the sequencer only stalls in
// its write state if the old result has still not been taken. Configuration writes take
// effect at once and belong between steps.
module plate_force_spring_damper_step (
  input  logic                              clk,
  input  logic                              rst_n,
  pfsd_stream_if.sink                       in_ch,
  pfsd_stream_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [pfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfsd_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PHASE    = 4'd1;
  localparam logic [3:0] S_W_VISC   = 4'd2;
  localparam logic [3:0] S_W_SPRING = 4'd3;
  localparam logic [3:0] S_RESID    = 4'd4;
  localparam logic [3:0] S_W_DAMP   = 4'd5;
  localparam logic [3:0] S_CTRL     = 4'd6;
  localparam logic [3:0] S_W_DV     = 4'd7;
  localparam logic [3:0] S_CAP      = 4'd8;
  localparam logic [3:0] S_W_TRIG   = 4'd9;
  localparam logic [3:0] S_DX       = 4'd10;
  localparam logic [3:0] S_W_DX     = 4'd11;
  localparam logic [3:0] S_WRITE    = 4'd12;

  function automatic logic signed [F_W-1:0] sat_to_f(input logic signed [SUM_W-1:0] x);
    logic signed [F_W-1:0] r;
    if (x > SLIM_F) begin
      r = F_W'(SLIM_F);
    end else if (x < -SLIM_F) begin
      r = F_W'(-SLIM_F);
    end else begin
      r = x[F_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [T_W-1:0] sat_to_t(input logic signed [SUM_W-1:0] x);
    logic signed [T_W-1:0] r;
    if (x > SLIM_T) begin
      r = T_W'(SLIM_T);
    end else if (x < -SLIM_T) begin
      r = T_W'(-SLIM_T);
    end else begin
      r = x[T_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [38:0] cf_r;
  logic [31:0] stiff_r;
  logic [15:0] frac_r;
  logic [39:0] visc_r;
  logic [31:0] appr_r;
  logic [31:0] cap_r;
  logic [31:0] cstart_r;
  logic [31:0] sstart_r;

  // control and plate state
  logic [3:0]            state_r, state_nxt;
  logic [STEP_W-1:0]     step_cnt_r, step_cnt_nxt;
  logic signed [F_W-1:0] v_r, v_nxt;
  logic signed [T_W-1:0] trans_r, trans_nxt;
  logic signed [T_W-1:0] anchor_r, anchor_nxt;
  logic                  fc_on_r, fc_on_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // per-step working registers
  logic signed [F_W-1:0]   f_r, f_nxt;
  logic signed [F_W-1:0]   drive_r, drive_nxt;
  logic signed [F_W-1:0]   damp_r, damp_nxt;
  logic signed [F_W-1:0]   spring_r, spring_nxt;
  logic signed [SUM_W-1:0] vsum_r, vsum_nxt;
  logic [1:0]              phase_r, phase_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                        in_fire;
  logic signed [NET_W-1:0]     resid;
  logic signed [NET_W-1:0]     net;
  logic signed [MUL_RES_W-1:0] damp_mag;
  logic signed [F_W-1:0]       v_sat;
  logic [F_W-1:0]              v_mag;
  logic [F_W-1:0]              f_mag;

  pfsd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // sums and magnitudes used by the sequencer
  assign resid    = NET_W'(f_r) - $signed({3'b000, cf_r}) - NET_W'(spring_r);
  assign net      = NET_W'(f_r) - NET_W'(drive_r) + NET_W'(damp_r);
  assign damp_mag = mul_rsp.res[MUL_RES_W-1] ? -mul_rsp.res : mul_rsp.res;
  assign v_sat    = sat_to_f(vsum_r);
  assign v_mag    = v_sat[F_W-1] ? F_W'(-v_sat) : F_W'(v_sat);
  assign f_mag    = f_r[F_W-1] ? F_W'(-f_r) : F_W'(f_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    v_nxt         = v_r;
    trans_nxt     = trans_r;
    anchor_nxt    = anchor_r;
    fc_on_nxt     = fc_on_r;
    out_valid_nxt = out_valid_r;
    f_nxt         = f_r;
    drive_nxt     = drive_r;
    damp_nxt      = damp_r;
    spring_nxt    = spring_r;
    vsum_nxt      = vsum_r;
    phase_nxt     = phase_r;
    out_data_nxt  = out_data_r;
    mul_req.start = 1'b0;
    mul_req.op    = MOP_VISC;
    mul_req.a     = '0;
    mul_req.b     = '0;

    // result beat taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          f_nxt = in_ch.data.measured_force_z;
          if (step_cnt_r != '1) begin
            step_cnt_nxt = step_cnt_r + STEP_W'(1);
          end
          state_nxt = S_PHASE;
        end
      end

      // pick the phase and, once coupled, start its first product
      S_PHASE: begin
        if (step_cnt_r <= cstart_r) begin
          phase_nxt = PHASE_OFF;
          drive_nxt = '0;
          damp_nxt  = '0;
          state_nxt = S_WRITE;
        end else if (step_cnt_r <= sstart_r) begin
          phase_nxt     = PHASE_COMPACT;
          drive_nxt     = $signed({1'b0, cf_r});
          anchor_nxt    = trans_r;
          mul_req.start = 1'b1;
          mul_req.op    = MOP_VISC;
          mul_req.a     = -MUL_A_W'(v_r);
          mul_req.b     = MUL_B_W'(visc_r);
          state_nxt     = S_W_VISC;
        end else begin
          phase_nxt     = PHASE_SPRING;
          mul_req.start = 1'b1;
          mul_req.op    = MOP_SPRING;
          mul_req.a     = MUL_A_W'(trans_r) - MUL_A_W'(anchor_r);
          mul_req.b     = MUL_B_W'(stiff_r);
          state_nxt     = S_W_SPRING;
        end
      end

      S_W_VISC: begin
        if (mul_rsp.done) begin
          damp_nxt  = F_W'(mul_rsp.res);
          state_nxt = S_CTRL;
        end
      end

      S_W_SPRING: begin
        if (mul_rsp.done) begin
          spring_nxt = F_W'(mul_rsp.res);
          state_nxt  = S_RESID;
        end
      end

      // drive force, then non-viscous damping from the force residual
      S_RESID: begin
        drive_nxt     = sat_to_f(SUM_W'($signed({1'b0, cf_r})) + SUM_W'(spring_r));
        mul_req.start = 1'b1;
        mul_req.op    = MOP_DAMP;
        mul_req.a     = MUL_A_W'(resid);
        mul_req.b     = MUL_B_W'(frac_r);
        state_nxt     = S_W_DAMP;
      end

      // damping opposes motion, none at rest
      S_W_DAMP: begin
        if (mul_rsp.done) begin
          if (v_r > 0) begin
            damp_nxt = -F_W'(damp_mag);
          end else if (v_r < 0) begin
            damp_nxt = F_W'(damp_mag);
          end else begin
            damp_nxt = '0;
          end
          state_nxt = S_CTRL;
        end
      end

      // force control integrates net force, approach tests the trigger
      S_CTRL: begin
        mul_req.start = 1'b1;
        if (fc_on_r) begin
          mul_req.op = MOP_DV;
          mul_req.a  = MUL_A_W'(net);
          mul_req.b  = MUL_B_W'(VELOCITY_GAIN_Q8);
          state_nxt  = S_W_DV;
        end else begin
          mul_req.op = MOP_TRIG;
          mul_req.a  = MUL_A_W'($signed({1'b0, cf_r}));
          mul_req.b  = MUL_B_W'(TRIGGER_FRACTION_Q16);
          state_nxt  = S_W_TRIG;
        end
      end

      S_W_DV: begin
        if (mul_rsp.done) begin
          vsum_nxt  = SUM_W'(v_r) + SUM_W'(mul_rsp.res);
          state_nxt = S_CAP;
        end
      end

      // speed cap
      S_CAP: begin
        if (v_mag > {8'b0, appr_r}) begin
          v_nxt = v_sat[F_W-1] ? -$signed({8'b0, cap_r}) : $signed({8'b0, cap_r});
        end else begin
          v_nxt = v_sat;
        end
        state_nxt = S_DX;
      end

      // trigger: |f| above the scaled compaction force, floor form
      S_W_TRIG: begin
        if (mul_rsp.done) begin
          v_nxt = -$signed({8'b0, appr_r});
          if ($signed({1'b0, f_mag}) > mul_rsp.res) begin
            fc_on_nxt = 1'b1;
          end
          state_nxt = S_DX;
        end
      end

      S_DX: begin
        mul_req.start = 1'b1;
        mul_req.op    = MOP_DX;
        mul_req.a     = MUL_A_W'(v_r);
        mul_req.b     = MUL_B_W'(STEP_TIME_Q16);
        state_nxt     = S_W_DX;
      end

      S_W_DX: begin
        if (mul_rsp.done) begin
          trans_nxt = sat_to_t(SUM_W'(trans_r) + SUM_W'(mul_rsp.res));
          state_nxt = S_WRITE;
        end
      end

      // hand the result to the output register once it is free
      S_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt.translation_z   = trans_r;
          out_data_nxt.velocity_z      = v_r;
          out_data_nxt.drive_force_z   = drive_r;
          out_data_nxt.damping_force_z = damp_r;
          out_data_nxt.phase           = phase_r;
          out_data_nxt.force_mode      = fc_on_r;
          out_valid_nxt                = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_r     <= RST_COMPACTION_FORCE;
      stiff_r  <= RST_SPRING_STIFFNESS;
      frac_r   <= RST_DAMPING_FRACTION;
      visc_r   <= RST_VISCOUS_DAMP_COEFF;
      appr_r   <= RST_APPROACH_VELOCITY;
      cap_r    <= RST_VELOCITY_CAP;
      cstart_r <= RST_COUPLING_START_STEP;
      sstart_r <= RST_SPRING_START_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPACTION_FORCE:    cf_r     <= cfg_data[38:0];
        CFG_SPRING_STIFFNESS:    stiff_r  <= cfg_data[31:0];
        CFG_DAMPING_FRACTION:    frac_r   <= cfg_data[15:0];
        CFG_VISCOUS_DAMP_COEFF:  visc_r   <= cfg_data[39:0];
        CFG_APPROACH_VELOCITY:   appr_r   <= cfg_data[31:0];
        CFG_VELOCITY_CAP:        cap_r    <= cfg_data[31:0];
        CFG_COUPLING_START_STEP: cstart_r <= cfg_data[31:0];
        CFG_SPRING_START_STEP:   sstart_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      v_r         <= '0;
      trans_r     <= '0;
      anchor_r    <= '0;
      fc_on_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      v_r         <= v_nxt;
      trans_r     <= trans_nxt;
      anchor_r    <= anchor_nxt;
      fc_on_r     <= fc_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
    f_r        <= f_nxt;
    drive_r    <= drive_nxt;
    damp_r     <= damp_nxt;
    spring_r   <= spring_nxt;
    vsum_r     <= vsum_nxt;
    phase_r    <= phase_nxt;
    out_data_r <= out_data_nxt;
  end

  // step counter moves only when a step beat is taken
  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(step_cnt_r))
    else $error("step counter changed without an input beat");

  // multiplier results arrive only while the sequencer waits for one
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_W_VISC || state_r == S_W_SPRING ||
                      state_r == S_W_DAMP || state_r == S_W_DV ||
                      state_r == S_W_TRIG || state_r == S_W_DX))
    else $error("multiplier result outside a wait state");

  // force control, once on, stays on
  a_fc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fc_on_r |=> fc_on_r)
    else $error("force control dropped");

  // uncoupled steps report no applied force
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.phase == PHASE_OFF) |->
      (out_data_r.drive_force_z == '0 && out_data_r.damping_force_z == '0))
    else $error("forces reported before coupling");

endmodule

// ===== hw/rtl/pfsd_mul.sv =====
// Shared sign-magnitude multiplier, 16 bits of the second operand per cycle, with shift and clamp
module pfsd_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  pfsd_pkg::mul_req_t req,
  output pfsd_pkg::mul_rsp_t rsp
);
  import pfsd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MUL_NDIG);
  localparam int unsigned PROD_W = MUL_MAG_W + MUL_DIG_W;

  logic                        run_r, run_nxt;
  logic                        fin_r, fin_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [MUL_MAG_W-1:0]        mag_r, mag_nxt;
  logic [MUL_B_W-1:0]          b_r, b_nxt;
  logic                        neg_r, neg_nxt;
  logic [MUL_OP_W-1:0]         op_r, op_nxt;
  logic [MUL_ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [MUL_RES_W-1:0] res_r, res_nxt;

  logic [PROD_W-1:0]    prod;
  logic [4:0]           sh;
  logic [MUL_MAG_W-1:0] lim;
  logic [MUL_ACC_W-1:0] shifted;
  logic                 over;
  logic [MUL_MAG_W-1:0] mag_sat;

  // scaling shift and clamp per operation
  always_comb begin
    unique case (op_r) inside
      MOP_VISC, MOP_SPRING: begin
        sh  = 5'd30;
        lim = MLIM_F;
      end
      MOP_DAMP, MOP_TRIG: begin
        sh  = 5'd16;
        lim = MLIM_F;
      end
      MOP_DV: begin
        sh  = 5'd8;
        lim = MLIM_DV;
      end
      MOP_DX: begin
        sh  = 5'd16;
        lim = MLIM_DX;
      end
      default: begin
        sh  = 5'd0;
        lim = '0;
      end
    endcase
  end

  // one digit partial product, most significant digit first
  assign prod    = PROD_W'(mag_r) * PROD_W'(b_r[MUL_B_W-1 -: MUL_DIG_W]);

  // truncate toward zero and clamp the magnitude
  assign shifted = acc_r >> sh;
  assign over    = (shifted[MUL_ACC_W-1:MUL_MAG_W] != '0) || (shifted[MUL_MAG_W-1:0] > lim);
  assign mag_sat = over ? lim : shifted[MUL_MAG_W-1:0];

  always_comb begin
    run_nxt  = run_r;
    fin_nxt  = 1'b0;
    done_nxt = fin_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;

    // load operands
    if (req.start && !run_r && !fin_r) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(MUL_NDIG - 1);
      neg_nxt = req.a[MUL_A_W-1];
      mag_nxt = req.a[MUL_A_W-1] ? MUL_MAG_W'(-req.a) : MUL_MAG_W'(req.a);
      b_nxt   = req.b;
      op_nxt  = req.op;
      acc_nxt = '0;
    end

    // accumulate digits
    if (run_r) begin
      acc_nxt = {acc_r[MUL_ACC_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}} + MUL_ACC_W'(prod);
      b_nxt   = b_r << MUL_DIG_W;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end

    // scale, clamp and sign
    if (fin_r) begin
      res_nxt = neg_r ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign rsp.busy = run_r || fin_r;
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
